[rtl/assert_macros.svh]
// Assertion helpers for checker files; tsrt_chk includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tsrt_pkg.sv]
package tsrt_pkg;

  localparam int PARK_DEPTH = 8;
  localparam int CNT_W = $clog2(PARK_DEPTH + 1);
  localparam int IDX_W = (PARK_DEPTH > 1) ? $clog2(PARK_DEPTH) : 1;

  localparam int FL_FIN = 0;
  localparam int FL_SYN = 1;
  localparam int FL_RST = 2;
  localparam int FL_ACK = 4;

  typedef enum logic [2:0] {
    ST_INITIAL = 3'd0,
    ST_SYN     = 3'd1,
    ST_SYNACK  = 3'd2,
    ST_EST     = 3'd3,
    ST_CLOSED  = 3'd4
  } conn_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EVAL,
    CS_DRAIN
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic eval;
    logic drain;
    logic emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic inspect;
    logic found;
  } dp_sts_t;

endpackage

[rtl/tsrt_ctrl.sv]
module tsrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tsrt_pkg::dp_sts_t sts_i,
  output tsrt_pkg::dp_cmd_t cmd_o
);
  import tsrt_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      CS_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = CS_EVAL;
        end
      end
      CS_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.inspect) begin
          state_d = CS_DRAIN;
        end else begin
          cmd_o.emit_last = 1'b1;
          state_d         = CS_IDLE;
        end
      end
      CS_DRAIN: begin
        cmd_o.drain = 1'b1;
        if (!sts_i.found) begin
          cmd_o.emit_last = 1'b1;
          state_d         = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

endmodule

[rtl/tsrt_dp.sv]
module tsrt_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic [31:0]       src_addr_i,
  input  logic [31:0]       seq_no_i,
  input  logic [7:0]        tcp_flags_i,
  input  logic [15:0]       payload_len_i,
  input  logic [15:0]       payload_handle_i,
  input  logic [15:0]       src_port_i,
  input  logic [15:0]       dst_port_i,
  input  tsrt_pkg::dp_cmd_t cmd_i,
  output tsrt_pkg::dp_sts_t sts_o,
  output logic              strobe_o,
  output logic              has_segment_o,
  output logic [31:0]       seg_offset_o,
  output logic [15:0]       seg_len_o,
  output logic [15:0]       seg_handle_o,
  output logic [15:0]       out_src_port_o,
  output logic [15:0]       out_dst_port_o,
  output logic              side_o,
  output logic [2:0]        conn_state_o,
  output logic              dropped_full_o,
  output logic              last_o
);
  import tsrt_pkg::*;

  logic [31:0]      init_addr_q;
  conn_state_e      cstate_q, cstate_d;
  logic [31:0]      init_seq_q [2];
  logic [31:0]      exp_seq_q  [2];
  logic             closed_q   [2];
  logic [CNT_W-1:0] cnt_q      [2];
  logic [31:0]      pk_seq_q   [2][PARK_DEPTH];
  logic [15:0]      pk_len_q   [2][PARK_DEPTH];
  logic [15:0]      pk_hnd_q   [2][PARK_DEPTH];

  logic [31:0] it_seq_q;
  logic [7:0]  it_flags_q;
  logic [15:0] it_len_q, it_hnd_q, it_sp_q, it_dp_q;
  logic        side_q, full_q;

  logic        pend_v_q;
  logic [31:0] pend_off_q;
  logic [15:0] pend_len_q, pend_hnd_q;

  logic        strobe_q, last_q, has_q;
  logic [31:0] off_q;
  logic [15:0] len_q, hnd_q;

  logic fin, syn, rst, ack;
  logic do_init, inspect, inorder, future, tbl_full;
  logic [31:0] diff;
  logic [31:0] exp_cur, init_cur;
  logic [CNT_W-1:0] cnt_cur;
  logic [PARK_DEPTH-1:0] match;
  logic [IDX_W-1:0] idx;
  logic found;
  logic [15:0] drn_len, drn_hnd;

  assign fin = it_flags_q[FL_FIN];
  assign syn = it_flags_q[FL_SYN];
  assign rst = it_flags_q[FL_RST];
  assign ack = it_flags_q[FL_ACK];

  assign exp_cur  = exp_seq_q[side_q];
  assign init_cur = init_seq_q[side_q];
  assign cnt_cur  = cnt_q[side_q];
  assign diff     = it_seq_q - exp_cur;
  assign inorder  = (diff == 32'd0);
  assign future   = !inorder && !diff[31];
  assign tbl_full = (cnt_cur == CNT_W'(PARK_DEPTH));

  always_comb begin
    cstate_d = cstate_q;
    do_init  = 1'b0;
    inspect  = 1'b0;
    unique case (cstate_q)
      ST_INITIAL: begin
        if (syn) begin
          cstate_d = ST_SYN;
          do_init  = 1'b1;
        end
      end
      ST_SYN: begin
        if (syn) begin
          if (ack) begin
            cstate_d = ST_SYNACK;
            do_init  = 1'b1;
          end
        end else begin
          cstate_d = ST_CLOSED;
        end
      end
      ST_SYNACK: begin
        if (fin || rst) begin
          cstate_d = ST_CLOSED;
        end else if (ack) begin
          inspect = 1'b1;
          if (inorder) cstate_d = ST_EST;
        end
      end
      ST_EST: begin
        inspect = 1'b1;
        if (fin) begin
          if (closed_q[!side_q]) cstate_d = ST_CLOSED;
        end else if (rst) begin
          cstate_d = ST_CLOSED;
        end
      end
      default: cstate_d = cstate_q;
    endcase
  end

  always_comb begin
    for (int i = 0; i < PARK_DEPTH; i++) begin
      match[i] = (CNT_W'(i) < cnt_cur) && (pk_seq_q[side_q][i] == exp_cur);
    end
    idx = '0;
    for (int i = PARK_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) idx = IDX_W'(i);
    end
  end

  assign found   = |match;
  assign drn_len = pk_len_q[side_q][idx];
  assign drn_hnd = pk_hnd_q[side_q][idx];

  assign sts_o.inspect = inspect;
  assign sts_o.found   = found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_addr_q <= '0;
      cstate_q    <= ST_INITIAL;
      for (int s = 0; s < 2; s++) begin
        init_seq_q[s] <= '0;
        exp_seq_q[s]  <= '0;
        closed_q[s]   <= 1'b0;
        cnt_q[s]      <= '0;
      end
      side_q   <= 1'b0;
      full_q   <= 1'b0;
      pend_v_q <= 1'b0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      has_q    <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit_last ||
                  (cmd_i.drain && found && (drn_len != 16'd0) && pend_v_q);
      if (cfg_we_i) init_addr_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        side_q   <= (src_addr_i != init_addr_q);
        full_q   <= 1'b0;
        pend_v_q <= 1'b0;
      end
      if (cmd_i.eval) begin
        cstate_q <= cstate_d;
        if (do_init) begin
          init_seq_q[side_q] <= it_seq_q;
          exp_seq_q[side_q]  <= it_seq_q + 32'd1;
        end
        if (inspect) begin
          if (inorder) begin
            exp_seq_q[side_q] <= exp_cur + {16'd0, it_len_q};
            if (it_len_q != 16'd0) pend_v_q <= 1'b1;
          end else if (future) begin
            if (tbl_full) full_q <= 1'b1;
            else cnt_q[side_q] <= cnt_cur + CNT_W'(1);
          end
        end
        if (cstate_q == ST_EST && fin) closed_q[side_q] <= 1'b1;
      end
      if (cmd_i.drain && found) begin
        exp_seq_q[side_q] <= exp_cur + {16'd0, drn_len};
        cnt_q[side_q]     <= cnt_cur - CNT_W'(1);
        if (drn_len != 16'd0) begin
          pend_v_q <= 1'b1;
          if (pend_v_q) begin
            last_q <= 1'b0;
            has_q  <= 1'b1;
          end
        end
      end
      if (cmd_i.emit_last) begin
        last_q <= 1'b1;
        has_q  <= pend_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_seq_q   <= seq_no_i;
      it_flags_q <= tcp_flags_i;
      it_len_q   <= payload_len_i;
      it_hnd_q   <= payload_handle_i;
      it_sp_q    <= src_port_i;
      it_dp_q    <= dst_port_i;
    end
    if (cmd_i.eval && inspect) begin
      if (inorder) begin
        pend_off_q <= it_seq_q - init_cur;
        pend_len_q <= it_len_q;
        pend_hnd_q <= it_hnd_q;
      end else if (future && !tbl_full) begin
        pk_seq_q[side_q][cnt_cur[IDX_W-1:0]] <= it_seq_q;
        pk_len_q[side_q][cnt_cur[IDX_W-1:0]] <= it_len_q;
        pk_hnd_q[side_q][cnt_cur[IDX_W-1:0]] <= it_hnd_q;
      end
    end
    if (cmd_i.drain && found) begin
      for (int k = 0; k < PARK_DEPTH - 1; k++) begin
        if (k >= int'(idx)) begin
          pk_seq_q[side_q][k] <= pk_seq_q[side_q][k+1];
          pk_len_q[side_q][k] <= pk_len_q[side_q][k+1];
          pk_hnd_q[side_q][k] <= pk_hnd_q[side_q][k+1];
        end
      end
      if (drn_len != 16'd0) begin
        pend_off_q <= exp_cur - init_cur;
        pend_len_q <= drn_len;
        pend_hnd_q <= drn_hnd;
        off_q      <= pend_off_q;
        len_q      <= pend_len_q;
        hnd_q      <= pend_hnd_q;
      end
    end
    if (cmd_i.emit_last) begin
      off_q <= pend_v_q ? pend_off_q : 32'd0;
      len_q <= pend_v_q ? pend_len_q : 16'd0;
      hnd_q <= pend_v_q ? pend_hnd_q : 16'd0;
    end
  end

  assign strobe_o       = strobe_q;
  assign has_segment_o  = has_q;
  assign seg_offset_o   = off_q;
  assign seg_len_o      = len_q;
  assign seg_handle_o   = hnd_q;
  assign out_src_port_o = it_sp_q;
  assign out_dst_port_o = it_dp_q;
  assign side_o         = side_q;
  assign conn_state_o   = cstate_q;
  assign dropped_full_o = full_q;
  assign last_o         = last_q;

endmodule

[rtl/tcp_stream_reassembly_tracker.sv]
// TCP stream reassembly tracker.
// Input: a segment descriptor word is taken at a rising edge with start high and
// busy low. Config: cfg_we_i writes cfg_wdata_i as the initiator source address;
// write only while idle.
// Output: each result word is on the result ports for one cycle with strobe_o
// high; last_o marks the final word of an item. The receiver cannot stall, and
// no result is ever held back waiting for it.
// Sequence: an accepted item is loaded, then evaluated; one that is not inspected
// against the stream (handshake items) ends there, else the drain state walks the
// per-side table one match per cycle until no parked entry matches. Busy drops on
// the cycle the last word shows.
// Each side parks up to PARK_DEPTH future segments in arrival order.
// Reset (rst_ni low, async) returns to the initial state with empty tables and
// the initiator address at zero; no clearing pass is needed.
module tcp_stream_reassembly_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] seq_no_i,
  input  logic [7:0]  tcp_flags_i,
  input  logic [15:0] payload_len_i,
  input  logic [15:0] payload_handle_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  output logic        strobe_o,
  output logic        has_segment_o,
  output logic [31:0] seg_offset_o,
  output logic [15:0] seg_len_o,
  output logic [15:0] seg_handle_o,
  output logic [15:0] out_src_port_o,
  output logic [15:0] out_dst_port_o,
  output logic        side_o,
  output logic [2:0]  conn_state_o,
  output logic        dropped_full_o,
  output logic        last_o
);
  import tsrt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tsrt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  tsrt_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .src_addr_i       (src_addr_i),
    .seq_no_i         (seq_no_i),
    .tcp_flags_i      (tcp_flags_i),
    .payload_len_i    (payload_len_i),
    .payload_handle_i (payload_handle_i),
    .src_port_i       (src_port_i),
    .dst_port_i       (dst_port_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .strobe_o         (strobe_o),
    .has_segment_o    (has_segment_o),
    .seg_offset_o     (seg_offset_o),
    .seg_len_o        (seg_len_o),
    .seg_handle_o     (seg_handle_o),
    .out_src_port_o   (out_src_port_o),
    .out_dst_port_o   (out_dst_port_o),
    .side_o           (side_o),
    .conn_state_o     (conn_state_o),
    .dropped_full_o   (dropped_full_o),
    .last_o           (last_o)
  );

endmodule

[rtl/tsrt_chk.sv]
`include "assert_macros.svh"

module tsrt_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        strobe_o,
  input logic        has_segment_o,
  input logic [31:0] seg_offset_o,
  input logic [15:0] seg_len_o,
  input logic        last_o
);

  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accept without busy")
  `ASSERT_IMPL(a_more_busy, clk_i, rst_ni, strobe_o && !last_o, busy, "idle mid item")
  `ASSERT_IMPL(a_empty_last, clk_i, rst_ni, strobe_o && !has_segment_o,
               last_o && seg_len_o == 16'd0 && seg_offset_o == 32'd0, "bad empty word")
  `ASSERT_IMPL(a_seg_len, clk_i, rst_ni, strobe_o && has_segment_o,
               seg_len_o != 16'd0, "empty segment delivered")

endmodule

bind tcp_stream_reassembly_tracker tsrt_chk u_tsrt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .strobe_o      (strobe_o),
  .has_segment_o (has_segment_o),
  .seg_offset_o  (seg_offset_o),
  .seg_len_o     (seg_len_o),
  .last_o        (last_o)
);

[tb/sv/testbench.sv]
module testbench;
  import tsrt_pkg::*;

  typedef struct {
    logic [31:0] src;
    logic [31:0] seq;
    logic [7:0]  flags;
    logic [15:0] len;
    logic [15:0] hnd;
    logic [15:0] sport;
    logic [15:0] dport;
  } seg_word_t;

  typedef struct {
    logic        has;
    logic [31:0] off;
    logic [15:0] len;
    logic [15:0] hnd;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        side;
    logic [2:0]  st;
    logic        full;
    logic        last;
  } out_word_t;

  typedef struct {
    logic [31:0] seq;
    logic [15:0] len;
    logic [15:0] hnd;
  } parked_t;

  class reassembly_sb;
    logic [31:0] initiator;
    conn_state_e st;
    logic [31:0] isn[2];
    logic [31:0] nxt[2];
    bit          fin_seen[2];
    parked_t     tbl[2][$];
    out_word_t   dl[$];
    out_word_t   exp_q[$];
    bit          full;
    int errors, n_words, n_deliv, n_full, n_out;

    function new();
      initiator = '0;
      st = ST_INITIAL;
      for (int s = 0; s < 2; s++) begin
        isn[s] = '0;
        nxt[s] = '0;
        fin_seen[s] = 0;
      end
    endfunction

    function void put(logic [31:0] off, logic [15:0] len, logic [15:0] hnd);
      out_word_t w;
      w = '{default: '0};
      w.has = 1;
      w.off = off;
      w.len = len;
      w.hnd = hnd;
      dl.push_back(w);
    endfunction

    function void drain(int s);
      bit found;
      found = 1;
      while (found) begin
        found = 0;
        for (int i = 0; i < tbl[s].size(); i++) begin
          if (tbl[s][i].seq == nxt[s]) begin
            if (tbl[s][i].len != 0) put(nxt[s] - isn[s], tbl[s][i].len, tbl[s][i].hnd);
            nxt[s] += 32'(tbl[s][i].len);
            tbl[s].delete(i);
            found = 1;
            break;
          end
        end
      end
    endfunction

    function bit inspect(int s, seg_word_t w);
      logic [31:0] d;
      d = w.seq - nxt[s];
      if (d == 0) begin
        nxt[s] += 32'(w.len);
        if (w.len != 0) put(w.seq - isn[s], w.len, w.hnd);
        drain(s);
        return 1;
      end
      if (d[31]) return 0;
      if (tbl[s].size() >= PARK_DEPTH) full = 1;
      else tbl[s].push_back('{w.seq, w.len, w.hnd});
      drain(s);
      return 0;
    endfunction

    function void note(seg_word_t w);
      int s;
      int n;
      out_word_t o;
      s = (w.src == initiator) ? 0 : 1;
      dl.delete();
      full = 0;
      n_words++;
      case (st)
        ST_INITIAL: if (w.flags[FL_SYN]) begin
          st = ST_SYN;
          isn[s] = w.seq;
          nxt[s] = w.seq + 1;
        end
        ST_SYN: begin
          if (w.flags[FL_SYN]) begin
            if (w.flags[FL_ACK]) begin
              st = ST_SYNACK;
              isn[s] = w.seq;
              nxt[s] = w.seq + 1;
            end
          end else st = ST_CLOSED;
        end
        ST_SYNACK: begin
          if (w.flags[FL_FIN] || w.flags[FL_RST]) st = ST_CLOSED;
          else if (w.flags[FL_ACK]) begin
            if (inspect(s, w)) st = ST_EST;
          end
        end
        ST_EST: begin
          void'(inspect(s, w));
          if (w.flags[FL_FIN]) begin
            fin_seen[s] = 1;
            if (fin_seen[s ^ 1]) st = ST_CLOSED;
          end else if (w.flags[FL_RST]) st = ST_CLOSED;
        end
        default: ;
      endcase
      if (dl.size() == 0) begin
        o = '{default: '0};
        dl.push_back(o);
      end
      n = dl.size();
      n_deliv += dl[0].has ? n : 0;
      if (full) n_full++;
      for (int k = 0; k < n; k++) begin
        o = dl[k];
        o.sport = w.sport;
        o.dport = w.dport;
        o.side = 1'(s);
        o.st = st;
        o.full = full;
        o.last = (k == n - 1);
        exp_q.push_back(o);
      end
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
      end
    endfunction

    function void check(out_word_t a);
      out_word_t e;
      n_out++;
      if (exp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, got offset %h len %h", $time, a.off, a.len);
        return;
      end
      e = exp_q.pop_front();
      cmp("has_segment", 32'(e.has), 32'(a.has));
      cmp("seg_offset", e.off, a.off);
      cmp("seg_len", 32'(e.len), 32'(a.len));
      cmp("seg_handle", 32'(e.hnd), 32'(a.hnd));
      cmp("out_src_port", 32'(e.sport), 32'(a.sport));
      cmp("out_dst_port", 32'(e.dport), 32'(a.dport));
      cmp("side", 32'(e.side), 32'(a.side));
      cmp("conn_state", 32'(e.st), 32'(a.st));
      cmp("dropped_full", 32'(e.full), 32'(a.full));
      cmp("last", 32'(e.last), 32'(a.last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        start;
  logic        busy;
  logic [31:0] src_addr_i;
  logic [31:0] seq_no_i;
  logic [7:0]  tcp_flags_i;
  logic [15:0] payload_len_i;
  logic [15:0] payload_handle_i;
  logic [15:0] src_port_i;
  logic [15:0] dst_port_i;
  logic        strobe_o;
  logic        has_segment_o;
  logic [31:0] seg_offset_o;
  logic [15:0] seg_len_o;
  logic [15:0] seg_handle_o;
  logic [15:0] out_src_port_o;
  logic [15:0] out_dst_port_o;
  logic        side_o;
  logic [2:0]  conn_state_o;
  logic        dropped_full_o;
  logic        last_o;

  tcp_stream_reassembly_tracker i_dut (.*);

  reassembly_sb sb = new();
  int   stall_cnt = 0;
  bit   burst;
  logic [31:0] peer_addr;

  localparam int STALL_LIMIT = 5000;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o)
      sb.check('{has_segment_o, seg_offset_o, seg_len_o, seg_handle_o, out_src_port_o,
                 out_dst_port_o, side_o, conn_state_o, dropped_full_o, last_o});
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(seg_word_t w);
    int gap;
    start            <= 1;
    src_addr_i       <= w.src;
    seq_no_i         <= w.seq;
    tcp_flags_i      <= w.flags;
    payload_len_i    <= w.len;
    payload_handle_i <= w.hnd;
    src_port_i       <= w.sport;
    dst_port_i       <= w.dport;
    do @(posedge clk_i); while (busy);
    sb.note(w);
    if (burst) gap = 0;
    else if ($urandom_range(0, 9) == 0) gap = $urandom_range(8, 40);
    else gap = $urandom_range(0, 2);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic set_initiator(logic [31:0] addr);
    start <= 0;
    while (sb.exp_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    cfg_we_i    <= 1;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.initiator = addr;
    do peer_addr = $urandom(); while (peer_addr == addr);
  endtask

  function automatic seg_word_t mk(int s, logic [31:0] seq, logic [7:0] flags,
                                   logic [15:0] len, logic [15:0] hnd);
    seg_word_t w;
    w.src = s ? peer_addr : sb.initiator;
    w.seq = seq;
    w.flags = flags;
    w.len = len;
    w.hnd = hnd;
    w.sport = 16'($urandom());
    w.dport = 16'($urandom());
    return w;
  endfunction

  task automatic random_block();
    int s, k;
    seg_word_t blk[$];
    seg_word_t w;
    logic [31:0] p;
    logic [7:0] fl;
    s = $urandom_range(0, 1);
    k = $urandom_range(1, 5);
    p = sb.nxt[s];
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < k; i++) begin
      fl = 8'($urandom());
      fl[FL_RST] = 0;
      fl[FL_FIN] = (s == 0) && ($urandom_range(0, 30) == 0);
      case ($urandom_range(0, 9))
        0: w = mk(s, 32'($urandom()), 8'($urandom()) & ~8'(1 << FL_RST) & ~8'(1 << FL_FIN),
                  16'($urandom()), 16'($urandom()));
        1: w = mk(s, 32'($urandom()), fl, 16'hFFFF, 16'($urandom()));
        default: w = mk(s, p, fl, ($urandom_range(0, 7) == 0) ? 16'd0
                                                    : 16'($urandom_range(1, 1500)),
                        16'($urandom()));
      endcase
      if (w.src != sb.initiator && s == 0) w.src = sb.initiator;
      if (s == 0 && w.flags[FL_FIN] == 0) w.flags[FL_FIN] = fl[FL_FIN];
      w.flags[FL_FIN] = (s == 0) ? w.flags[FL_FIN] : 1'b0;
      if (w.seq == p) p += 32'(w.len);
      blk.push_back(w);
    end
    blk.shuffle();
    foreach (blk[i]) send(blk[i]);
  endtask

  initial begin
    seg_word_t w;
    logic [31:0] b;
    int sent;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = '0;
    start = 0;
    src_addr_i = '0;
    seq_no_i = '0;
    tcp_flags_i = '0;
    payload_len_i = '0;
    payload_handle_i = '0;
    src_port_i = '0;
    dst_port_i = '0;
    burst = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    set_initiator(32'hFFFF_FFFF);

    // handshake, with noise and a parked ACK in syn-ack
    send(mk(0, 32'h1234_5678, 8'(1 << FL_ACK), 16'd7, 16'd1));
    send(mk(0, 32'hFFFF_FFFF, 8'(1 << FL_SYN), 16'd0, 16'd0));
    send(mk(1, 32'h5555_5555, 8'(1 << FL_SYN), 16'd0, 16'd0));
    send(mk(1, 32'h7FFF_FFFF, 8'((1 << FL_SYN) | (1 << FL_ACK)), 16'd0, 16'd0));
    send(mk(0, 32'd0, 8'h00, 16'd4, 16'd2));
    send(mk(0, 32'd10, 8'(1 << FL_ACK), 16'd5, 16'hFFFF));
    send(mk(0, 32'h8000_0000, 8'(1 << FL_ACK), 16'd3, 16'd3));
    send(mk(0, 32'd0, 8'(1 << FL_ACK), 16'd10, 16'd0));
    // fill the reverse table, overflow it, then release all in one go
    b = sb.nxt[1];
    for (int i = 0; i < PARK_DEPTH; i++)
      send(mk(1, b + 1 + 32'(i), 8'(1 << FL_ACK), 16'd1, 16'(100 + i)));
    send(mk(1, b + 100, 8'(1 << FL_ACK), 16'd9, 16'd9));
    send(mk(1, b, 8'(1 << FL_ACK), 16'd1, 16'd99));
    // zero-length segments, port and size extremes
    w = mk(0, 32'd15, 8'(1 << FL_ACK), 16'd0, 16'd0);
    w.sport = 16'hFFFF;
    w.dport = 16'h0000;
    send(w);
    send(mk(0, 32'd20, 8'(1 << FL_ACK), 16'd0, 16'd5));
    w = mk(0, 32'd15, 8'hEA, 16'd5, 16'hFFFF);
    w.sport = 16'h0000;
    w.dport = 16'hFFFF;
    send(w);
    send(mk(0, 32'd20, 8'(1 << FL_ACK), 16'hFFFF, 16'hA5A5));

    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: set_initiator(32'h0);
        default: if (ph > 0) set_initiator($urandom());
      endcase
      while (sent < 24 * (ph + 1)) begin
        random_block();
        sent = sb.n_words - 22;
      end
    end

    // close both directions, then items after close are ignored
    burst = 0;
    send(mk(0, sb.nxt[0], 8'((1 << FL_FIN) | (1 << FL_ACK)), 16'd0, 16'd0));
    send(mk(1, sb.nxt[1], 8'((1 << FL_FIN) | (1 << FL_RST) | (1 << FL_ACK)), 16'd8, 16'd7));
    send(mk(0, 32'($urandom()), 8'hFF, 16'd1, 16'd1));
    send(mk(1, 32'($urandom()), 8'(1 << FL_SYN), 16'd1, 16'd1));
    start <= 0;

    while (sb.exp_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("Sent %0d segment words over 4 initiator settings; %0d result words checked,",
             sb.n_words, sb.n_out);
    $display("%0d segments delivered, %0d full-table drops.", sb.n_deliv, sb.n_full);
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
